FILE: rtl/core/classification_metrics_counter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for classification_metrics_counter
// Implication checks clocked on aclk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CLASSIFICATION_METRICS_COUNTER_DEFINES_SVH
`define CLASSIFICATION_METRICS_COUNTER_DEFINES_SVH

// same-cycle implication
`define CMC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CMC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cmc_pkg.sv
// ----------------------------------------------------------------------------
// cmc_pkg
// Shared types and constants of the classification metrics counter.
// ----------------------------------------------------------------------------
package cmc_pkg;

    localparam int MAX_CLASSES_DEF   = 16;
    localparam int COUNT_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int CFG_W       = 5;
    localparam int CLS_FIELD_W = 4;
    localparam int IN_W        = 16;
    localparam int OUT_W       = 296;
    localparam int OUT_CNT_W   = 32;
    localparam int OUT_Q_W     = 17;

    localparam logic [CFG_W-1:0] NUM_CLASSES_RST = 5'd16;

    // m_tdata field offsets
    localparam int OFS_TP      = 0;
    localparam int OFS_FP      = 32;
    localparam int OFS_FN      = 64;
    localparam int OFS_TN      = 96;
    localparam int OFS_PREC    = 128;
    localparam int OFS_REC     = 145;
    localparam int OFS_CELL    = 162;
    localparam int OFS_CFRAC   = 194;
    localparam int OFS_SAMPLES = 211;
    localparam int OFS_ACC     = 243;
    localparam int OFS_MPREC   = 260;
    localparam int OFS_MREC    = 277;

    typedef enum logic [2:0] {
        CMD_RECORD      = 3'd0,
        CMD_READ_CLASS  = 3'd1,
        CMD_READ_CELL   = 3'd2,
        CMD_READ_TOTALS = 3'd3,
        CMD_CLEAR       = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REC,
        ST_LOAD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

endpackage

FILE: rtl/core/cmc_ram.sv
// ----------------------------------------------------------------------------
// cmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/cmc_divider.sv
// ----------------------------------------------------------------------------
// cmc_divider
// Restoring fraction divider: floor(num * 2^Q_BITS / den), one bit a cycle,
// saturating at 1.0 and zero for a zero divisor.
// ----------------------------------------------------------------------------
module cmc_divider #(
    parameter int NUM_W  = 33,
    parameter int Q_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [NUM_W-1:0] den,
    output logic             done,
    output logic [Q_BITS:0]  quot
);

    localparam int CNT_W = $clog2(Q_BITS + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] r_reg;
    logic [NUM_W-1:0] d_reg;
    logic [Q_BITS:0]  q_reg;
    logic [NUM_W:0]   trial;
    logic             ge;
    logic [NUM_W:0]   diff;

    assign trial = {r_reg, 1'b0};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (den == '0) begin
                    q_reg    <= '0;
                    done_reg <= 1'b1;
                end else if (num >= den) begin
                    q_reg    <= {1'b1, {Q_BITS{1'b0}}};
                    done_reg <= 1'b1;
                end else begin
                    r_reg    <= num;
                    d_reg    <= den;
                    q_reg    <= '0;
                    cnt_reg  <= CNT_W'(Q_BITS);
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                r_reg   <= ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
                q_reg   <= {q_reg[Q_BITS-1:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

FILE: rtl/core/classification_metrics_counter.sv
// ----------------------------------------------------------------------------
// classification_metrics_counter
// Confusion matrix with per-class and micro precision / recall.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes command items: record a (predicted, true) pair, read one
//   class, read one confusion cell, read the totals, or clear everything.
//   m_ channel returns one item per accepted read; records and clears return
//   nothing. Items whose class indices are at or above num_classes or MAX_CLASSES are dropped.
//   cfg_ writes num_classes; write it only while the block is idle.
// Sequencing:
//   A record is a counter memory read, then a saturating write-back.
//   A read loads the counters from memory (class and cell reads only), then
//   runs one divider quotient per result fraction: 2, 1, 3 quotients for class,
//   cell, totals. A quotient with a zero divisor or a dividend at or above it
//   skips the bit-by-bit division. The result then goes to the output register.
//   A clear sweeps all 2^(2*ceil(log2(MAX_CLASSES))) confusion memory entries
//   (256 by default), during which s_tready is low.
// Reset:
//   The same clearing sweep runs after aresetn; num_classes returns to 16.
// Stall:
//   A held result waits in the output register; the next item is accepted from
//   the cycle after it is loaded, and a further read waits for it to empty.
// ----------------------------------------------------------------------------
`include "classification_metrics_counter_defines.svh"

module classification_metrics_counter #(
    parameter int MAX_CLASSES   = cmc_pkg::MAX_CLASSES_DEF,
    parameter int COUNT_BITS    = cmc_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = cmc_pkg::FRACTION_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cmc_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // command[2:0], predicted_class[6:3], true_class[10:7], query_class[14:11]
    input  logic [cmc_pkg::IN_W-1:0]     s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // class_tp, class_fp, class_fn, class_tn, class_precision, class_recall,
    // cell_count, cell_fraction, sample_count, overall_accuracy,
    // micro_precision, micro_recall
    output logic [cmc_pkg::OUT_W-1:0]    m_tdata
);

    localparam int CLS_W      = $clog2(MAX_CLASSES);
    localparam int CLS_DEPTH  = 1 << CLS_W;
    localparam int CELL_AW    = 2 * CLS_W;
    localparam int CELL_DEPTH = 1 << CELL_AW;
    localparam int CNT_W      = COUNT_BITS;
    localparam int SUM_W      = COUNT_BITS + 1;
    localparam int Q_W        = FRACTION_BITS + 1;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        sat_inc = (x == '1) ? x : x + 1'b1;
    endfunction

    cmc_pkg::state_t state_reg, state_next;

    logic [cmc_pkg::CFG_W-1:0] num_classes_reg;
    logic [2:0]                cmd_reg;
    logic [CLS_W-1:0]          pc_reg, tc_reg;
    logic [CELL_AW-1:0]        clr_cnt_reg;
    logic [1:0]                job_reg;
    logic [CNT_W-1:0]          a_reg, b_reg, c_reg;
    logic [CNT_W-1:0]          correct_reg, sample_reg, fpt_reg, fnt_reg;
    logic [Q_W-1:0]            q0_reg, q1_reg, q2_reg;
    logic                      m_tvalid_reg;
    logic [cmc_pkg::OUT_W-1:0] m_tdata_reg;

    logic [2:0]            in_cmd;
    logic [3:0]            in_pc, in_tc, in_qc;
    logic [7:0]            lim8;
    logic                  pc_ok, tc_ok, qc_ok;
    logic                  accept;
    logic                  out_load;
    logic                  match;

    logic                  tp_we, fp_we, fn_we, cell_we;
    logic [CLS_W-1:0]      tp_waddr, fp_waddr, fn_waddr;
    logic [CLS_W-1:0]      tp_raddr, fp_raddr, fn_raddr;
    logic [CELL_AW-1:0]    cell_waddr, cell_raddr;
    logic [CNT_W-1:0]      tp_wdata, fp_wdata, fn_wdata, cell_wdata;
    logic [CNT_W-1:0]      tp_rdata, fp_rdata, fn_rdata, cell_rdata;

    logic                  div_start, div_done;
    logic [SUM_W-1:0]      div_num, div_den;
    logic [Q_W-1:0]        div_quot;
    logic                  job_last;
    logic [CNT_W-1:0]      tn_val;
    logic [cmc_pkg::OUT_W-1:0] out_word;

    assign in_cmd = s_tdata[2:0];
    assign in_pc  = s_tdata[6:3];
    assign in_tc  = s_tdata[10:7];
    assign in_qc  = s_tdata[14:11];

    assign lim8  = ({3'b0, num_classes_reg} < 8'(MAX_CLASSES)) ?
                   {3'b0, num_classes_reg} : 8'(MAX_CLASSES);
    assign pc_ok = {4'b0, in_pc} < lim8;
    assign tc_ok = {4'b0, in_tc} < lim8;
    assign qc_ok = {4'b0, in_qc} < lim8;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == cmc_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign match     = (pc_reg == tc_reg);
    assign out_load  = (state_reg == cmc_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);

    // read addresses: from the incoming item while idle, otherwise held
    always_comb begin
        if (state_reg == cmc_pkg::ST_IDLE) begin
            tp_raddr   = (in_cmd == cmc_pkg::CMD_READ_CLASS) ? CLS_W'(in_qc) : CLS_W'(in_tc);
            fn_raddr   = tp_raddr;
            fp_raddr   = (in_cmd == cmc_pkg::CMD_READ_CLASS) ? CLS_W'(in_qc) : CLS_W'(in_pc);
            cell_raddr = {CLS_W'(in_pc), CLS_W'(in_tc)};
        end else begin
            tp_raddr   = tc_reg;
            fn_raddr   = tc_reg;
            fp_raddr   = pc_reg;
            cell_raddr = {pc_reg, tc_reg};
        end
    end

    // divider operands per job
    always_comb begin
        div_num  = {1'b0, correct_reg};
        div_den  = {1'b0, sample_reg};
        job_last = 1'b1;
        unique case (cmd_reg)
            cmc_pkg::CMD_READ_CLASS: begin
                div_num  = {1'b0, a_reg};
                div_den  = (job_reg == 2'd0) ? ({1'b0, a_reg} + {1'b0, b_reg}) :
                                               ({1'b0, a_reg} + {1'b0, c_reg});
                job_last = (job_reg == 2'd1);
            end
            cmc_pkg::CMD_READ_CELL: begin
                div_num  = {1'b0, a_reg};
                div_den  = {1'b0, sample_reg};
                job_last = 1'b1;
            end
            default: begin
                div_num = {1'b0, correct_reg};
                if (job_reg == 2'd1) begin
                    div_den = {1'b0, correct_reg} + {1'b0, fpt_reg};
                end else if (job_reg == 2'd2) begin
                    div_den = {1'b0, correct_reg} + {1'b0, fnt_reg};
                end
                job_last = (job_reg == 2'd2);
            end
        endcase
    end

    // next state and memory controls
    always_comb begin
        state_next = state_reg;
        tp_we      = 1'b0;
        fp_we      = 1'b0;
        fn_we      = 1'b0;
        cell_we    = 1'b0;
        tp_waddr   = tc_reg;
        fp_waddr   = pc_reg;
        fn_waddr   = tc_reg;
        cell_waddr = {pc_reg, tc_reg};
        tp_wdata   = sat_inc(tp_rdata);
        fp_wdata   = sat_inc(fp_rdata);
        fn_wdata   = sat_inc(fn_rdata);
        cell_wdata = sat_inc(cell_rdata);
        div_start  = 1'b0;
        unique case (state_reg)
            cmc_pkg::ST_CLEAR: begin
                tp_we      = 1'b1;
                fp_we      = 1'b1;
                fn_we      = 1'b1;
                cell_we    = 1'b1;
                tp_waddr   = clr_cnt_reg[CLS_W-1:0];
                fp_waddr   = clr_cnt_reg[CLS_W-1:0];
                fn_waddr   = clr_cnt_reg[CLS_W-1:0];
                cell_waddr = clr_cnt_reg;
                tp_wdata   = '0;
                fp_wdata   = '0;
                fn_wdata   = '0;
                cell_wdata = '0;
                if (clr_cnt_reg == '1) begin
                    state_next = cmc_pkg::ST_IDLE;
                end
            end
            cmc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_cmd == cmc_pkg::CMD_RECORD && pc_ok && tc_ok) begin
                        state_next = cmc_pkg::ST_REC;
                    end else if (in_cmd == cmc_pkg::CMD_READ_CLASS && qc_ok) begin
                        state_next = cmc_pkg::ST_LOAD;
                    end else if (in_cmd == cmc_pkg::CMD_READ_CELL && pc_ok && tc_ok) begin
                        state_next = cmc_pkg::ST_LOAD;
                    end else if (in_cmd == cmc_pkg::CMD_READ_TOTALS) begin
                        state_next = cmc_pkg::ST_DIV_START;
                    end else if (in_cmd == cmc_pkg::CMD_CLEAR) begin
                        state_next = cmc_pkg::ST_CLEAR;
                    end
                end
            end
            cmc_pkg::ST_REC: begin
                tp_we      = match;
                fp_we      = !match;
                fn_we      = !match;
                cell_we    = 1'b1;
                state_next = cmc_pkg::ST_IDLE;
            end
            cmc_pkg::ST_LOAD: begin
                state_next = cmc_pkg::ST_DIV_START;
            end
            cmc_pkg::ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = cmc_pkg::ST_DIV_WAIT;
            end
            cmc_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = job_last ? cmc_pkg::ST_OUT : cmc_pkg::ST_DIV_START;
                end
            end
            cmc_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = cmc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cmc_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // control and totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_classes_reg <= cmc_pkg::NUM_CLASSES_RST;
            clr_cnt_reg     <= '0;
            job_reg         <= '0;
            correct_reg     <= '0;
            sample_reg      <= '0;
            fpt_reg         <= '0;
            fnt_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                num_classes_reg <= cfg_data;
            end
            if (state_reg == cmc_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (accept && in_cmd == cmc_pkg::CMD_CLEAR) begin
                correct_reg <= '0;
                sample_reg  <= '0;
                fpt_reg     <= '0;
                fnt_reg     <= '0;
            end
            if (state_reg == cmc_pkg::ST_REC) begin
                sample_reg <= sat_inc(sample_reg);
                if (match) begin
                    correct_reg <= sat_inc(correct_reg);
                end else begin
                    fpt_reg <= sat_inc(fpt_reg);
                    fnt_reg <= sat_inc(fnt_reg);
                end
            end
            if (accept) begin
                job_reg <= '0;
            end else if (state_reg == cmc_pkg::ST_DIV_WAIT && div_done && !job_last) begin
                job_reg <= job_reg + 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= in_cmd;
            pc_reg  <= CLS_W'(in_pc);
            tc_reg  <= CLS_W'(in_tc);
        end
        if (state_reg == cmc_pkg::ST_LOAD) begin
            a_reg <= (cmd_reg == cmc_pkg::CMD_READ_CELL) ? cell_rdata : tp_rdata;
            b_reg <= fp_rdata;
            c_reg <= fn_rdata;
        end
        if (state_reg == cmc_pkg::ST_DIV_WAIT && div_done) begin
            unique case (job_reg)
                2'd0:    q0_reg <= div_quot;
                2'd1:    q1_reg <= div_quot;
                default: q2_reg <= div_quot;
            endcase
        end
        if (out_load) begin
            m_tdata_reg <= out_word;
        end
    end

    assign tn_val = (correct_reg >= a_reg) ? correct_reg - a_reg : '0;

    always_comb begin
        out_word = '0;
        unique case (cmd_reg)
            cmc_pkg::CMD_READ_CLASS: begin
                out_word[cmc_pkg::OFS_TP +: cmc_pkg::OUT_CNT_W]   = cmc_pkg::OUT_CNT_W'(a_reg);
                out_word[cmc_pkg::OFS_FP +: cmc_pkg::OUT_CNT_W]   = cmc_pkg::OUT_CNT_W'(b_reg);
                out_word[cmc_pkg::OFS_FN +: cmc_pkg::OUT_CNT_W]   = cmc_pkg::OUT_CNT_W'(c_reg);
                out_word[cmc_pkg::OFS_TN +: cmc_pkg::OUT_CNT_W]   = cmc_pkg::OUT_CNT_W'(tn_val);
                out_word[cmc_pkg::OFS_PREC +: cmc_pkg::OUT_Q_W]   = cmc_pkg::OUT_Q_W'(q0_reg);
                out_word[cmc_pkg::OFS_REC +: cmc_pkg::OUT_Q_W]    = cmc_pkg::OUT_Q_W'(q1_reg);
            end
            cmc_pkg::CMD_READ_CELL: begin
                out_word[cmc_pkg::OFS_CELL +: cmc_pkg::OUT_CNT_W] = cmc_pkg::OUT_CNT_W'(a_reg);
                out_word[cmc_pkg::OFS_CFRAC +: cmc_pkg::OUT_Q_W]  = cmc_pkg::OUT_Q_W'(q0_reg);
            end
            default: begin
                out_word[cmc_pkg::OFS_SAMPLES +: cmc_pkg::OUT_CNT_W] =
                    cmc_pkg::OUT_CNT_W'(sample_reg);
                out_word[cmc_pkg::OFS_ACC +: cmc_pkg::OUT_Q_W]   = cmc_pkg::OUT_Q_W'(q0_reg);
                out_word[cmc_pkg::OFS_MPREC +: cmc_pkg::OUT_Q_W] = cmc_pkg::OUT_Q_W'(q1_reg);
                out_word[cmc_pkg::OFS_MREC +: cmc_pkg::OUT_Q_W]  = cmc_pkg::OUT_Q_W'(q2_reg);
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    cmc_ram #(.WIDTH(CNT_W), .DEPTH(CLS_DEPTH)) u_tp_ram (
        .aclk(aclk), .we(tp_we), .waddr(tp_waddr), .wdata(tp_wdata),
        .raddr(tp_raddr), .rdata(tp_rdata)
    );

    cmc_ram #(.WIDTH(CNT_W), .DEPTH(CLS_DEPTH)) u_fp_ram (
        .aclk(aclk), .we(fp_we), .waddr(fp_waddr), .wdata(fp_wdata),
        .raddr(fp_raddr), .rdata(fp_rdata)
    );

    cmc_ram #(.WIDTH(CNT_W), .DEPTH(CLS_DEPTH)) u_fn_ram (
        .aclk(aclk), .we(fn_we), .waddr(fn_waddr), .wdata(fn_wdata),
        .raddr(fn_raddr), .rdata(fn_rdata)
    );

    cmc_ram #(.WIDTH(CNT_W), .DEPTH(CELL_DEPTH)) u_cell_ram (
        .aclk(aclk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
        .raddr(cell_raddr), .rdata(cell_rdata)
    );

    cmc_divider #(.NUM_W(SUM_W), .Q_BITS(FRACTION_BITS)) u_divider (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(div_den), .done(div_done), .quot(div_quot)
    );

    `CMC_ASSERT_NXT(a_rec_two_cycles, state_reg == cmc_pkg::ST_REC,
        state_reg == cmc_pkg::ST_IDLE, "record write-back did not return to idle")
    `CMC_ASSERT_IMP(a_div_done_waiting, div_done,
        state_reg == cmc_pkg::ST_DIV_WAIT, "divider finished with no job waiting")
    `CMC_ASSERT_IMP(a_correct_le_samples, 1'b1,
        correct_reg <= sample_reg && fpt_reg <= sample_reg, "totals exceed sample count")

endmodule

FILE: tb/classification_metrics_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// classification_metrics_counter_tb
// Stream-level test of the metrics counter: records, class/cell/totals reads,
// clears and class-count settings are driven with random gaps and stalls,
// and every read result is compared field by field with a local tally model.
// ----------------------------------------------------------------------------

class metrics_scoreboard;
    localparam int NCLS = cmc_pkg::MAX_CLASSES_DEF;
    localparam int OW   = cmc_pkg::OUT_W;
    localparam int QW   = cmc_pkg::OUT_Q_W;
    typedef logic [OW-1:0] result_t;

    longint unsigned tp_cnt[NCLS];
    longint unsigned fp_cnt[NCLS];
    longint unsigned fn_cnt[NCLS];
    longint unsigned cell_cnt[NCLS*NCLS];
    longint unsigned correct_sum, sample_sum, fp_sum, fn_sum;
    int unsigned class_limit;
    result_t pending[$];
    int mismatches;

    function new();
        class_limit = cmc_pkg::NUM_CLASSES_RST;
        mismatches = 0;
        wipe();
    endfunction

    function void wipe();
        foreach (tp_cnt[i]) begin
            tp_cnt[i] = 0;
            fp_cnt[i] = 0;
            fn_cnt[i] = 0;
        end
        foreach (cell_cnt[i]) cell_cnt[i] = 0;
        correct_sum = 0;
        sample_sum = 0;
        fp_sum = 0;
        fn_sum = 0;
    endfunction

    function void set_classes(logic [cmc_pkg::CFG_W-1:0] v);
        class_limit = (v < NCLS) ? v : NCLS;
    endfunction

    function longint unsigned bump(longint unsigned c);
        return (c < 64'hFFFF_FFFF) ? c + 1 : c;
    endfunction

    function logic [QW-1:0] ratio(longint unsigned num, longint unsigned den);
        if (den == 0) return '0;
        if (num >= den) return 17'h10000;
        return QW'((num << cmc_pkg::FRACTION_BITS_DEF) / den);
    endfunction

    function void expect_item(result_t r);
        pending = {pending, r};
    endfunction

    function void note(cmc_pkg::cmd_t cmd, int unsigned pc, int unsigned tc, int unsigned qc);
        result_t r;
        longint unsigned tp, fp, fn;
        r = '0;
        case (cmd)
            cmc_pkg::CMD_RECORD: begin
                if (pc >= class_limit || tc >= class_limit) return;
                sample_sum = bump(sample_sum);
                if (pc == tc) begin
                    tp_cnt[tc] = bump(tp_cnt[tc]);
                    correct_sum = bump(correct_sum);
                end else begin
                    fp_cnt[pc] = bump(fp_cnt[pc]);
                    fn_cnt[tc] = bump(fn_cnt[tc]);
                    fp_sum = bump(fp_sum);
                    fn_sum = bump(fn_sum);
                end
                cell_cnt[pc*NCLS+tc] = bump(cell_cnt[pc*NCLS+tc]);
            end
            cmc_pkg::CMD_READ_CLASS: begin
                if (qc >= class_limit) return;
                tp = tp_cnt[qc];
                fp = fp_cnt[qc];
                fn = fn_cnt[qc];
                r[cmc_pkg::OFS_TP +: 32] = tp[31:0];
                r[cmc_pkg::OFS_FP +: 32] = fp[31:0];
                r[cmc_pkg::OFS_FN +: 32] = fn[31:0];
                r[cmc_pkg::OFS_TN +: 32] = (correct_sum >= tp) ? 32'(correct_sum - tp) : 32'd0;
                r[cmc_pkg::OFS_PREC +: 17] = ratio(tp, tp + fp);
                r[cmc_pkg::OFS_REC +: 17] = ratio(tp, tp + fn);
                expect_item(r);
            end
            cmc_pkg::CMD_READ_CELL: begin
                if (pc >= class_limit || tc >= class_limit) return;
                r[cmc_pkg::OFS_CELL +: 32] = cell_cnt[pc*NCLS+tc][31:0];
                r[cmc_pkg::OFS_CFRAC +: 17] = ratio(cell_cnt[pc*NCLS+tc], sample_sum);
                expect_item(r);
            end
            cmc_pkg::CMD_READ_TOTALS: begin
                r[cmc_pkg::OFS_SAMPLES +: 32] = sample_sum[31:0];
                r[cmc_pkg::OFS_ACC +: 17] = ratio(correct_sum, sample_sum);
                r[cmc_pkg::OFS_MPREC +: 17] = ratio(correct_sum, correct_sum + fp_sum);
                r[cmc_pkg::OFS_MREC +: 17] = ratio(correct_sum, correct_sum + fn_sum);
                expect_item(r);
            end
            cmc_pkg::CMD_CLEAR: wipe();
            default: ;
        endcase
    endfunction

    function void check(result_t got);
        int ofs[12] = '{cmc_pkg::OFS_TP, cmc_pkg::OFS_FP, cmc_pkg::OFS_FN, cmc_pkg::OFS_TN,
                        cmc_pkg::OFS_PREC, cmc_pkg::OFS_REC, cmc_pkg::OFS_CELL,
                        cmc_pkg::OFS_CFRAC, cmc_pkg::OFS_SAMPLES, cmc_pkg::OFS_ACC,
                        cmc_pkg::OFS_MPREC, cmc_pkg::OFS_MREC};
        int wid[12] = '{32, 32, 32, 32, 17, 17, 32, 17, 32, 17, 17, 17};
        result_t want;
        logic [31:0] a, b;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("expected no result item, got %h", got);
            return;
        end
        want = pending.pop_front();
        for (int f = 0; f < 12; f++) begin
            a = 32'((want >> ofs[f]) & ((OW'(1) << wid[f]) - 1));
            b = 32'((got >> ofs[f]) & ((OW'(1) << wid[f]) - 1));
            if (a !== b) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("field %0d at bit %0d: expected %h, got %h", f, ofs[f], a, b);
            end
        end
    endfunction
endclass

module classification_metrics_counter_tb;
    localparam int CYCLE_LIMIT = 1000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [cmc_pkg::CFG_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [cmc_pkg::IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [cmc_pkg::OUT_W-1:0] m_tdata;

    metrics_scoreboard sb = new();
    bit no_idle = 1'b0;
    bit hold = 1'b0;
    int unsigned cycles = 0;
    int unsigned eff_classes = 16;

    classification_metrics_counter u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side
    initial begin
        int gap;
        @(posedge aclk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 5);
            repeat (gap) begin
                m_tready <= 1'b0;
                @(posedge aclk);
            end
            m_tready <= !hold;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) begin
                m_tready <= !hold;
                @(posedge aclk);
            end
            sb.check(m_tdata);
        end
    end

    // long receiver hold-off so the block backs up
    initial begin
        repeat (3000) @(posedge aclk);
        hold <= 1'b1;
        repeat (800) @(posedge aclk);
        hold <= 1'b0;
    end

    task automatic send(cmc_pkg::cmd_t cmd, int unsigned pc, int unsigned tc,
                        int unsigned qc);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, qc[3:0], tc[3:0], pc[3:0], cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note(cmd, pc, tc, qc);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic set_classes(logic [cmc_pkg::CFG_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_classes(v);
        eff_classes = (v < 16) ? v : 16;
    endtask

    function automatic int unsigned pick_class();
        if (eff_classes > 0 && $urandom_range(0, 9) != 0)
            return $urandom_range(0, eff_classes - 1);
        return $urandom_range(0, 15);
    endfunction

    task automatic random_items(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) send(cmc_pkg::CMD_RECORD, pick_class(), pick_class(),
                             $urandom_range(0, 15));
            else if (r < 80) send(cmc_pkg::CMD_READ_CLASS, $urandom_range(0, 15),
                                  $urandom_range(0, 15), pick_class());
            else if (r < 88) send(cmc_pkg::CMD_READ_CELL, pick_class(), pick_class(),
                                  $urandom_range(0, 15));
            else if (r < 95) send(cmc_pkg::CMD_READ_TOTALS, $urandom_range(0, 15),
                                  $urandom_range(0, 15), $urandom_range(0, 15));
            else if (r < 96) send(cmc_pkg::CMD_CLEAR, 0, 0, 0);
            else send(cmc_pkg::cmd_t'($urandom_range(5, 7)), $urandom_range(0, 15),
                      $urandom_range(0, 15), $urandom_range(0, 15));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty totals, extremes, unknown codes, clear
        send(cmc_pkg::CMD_READ_TOTALS, 0, 0, 0);
        send(cmc_pkg::CMD_READ_CELL, 15, 15, 0);
        send(cmc_pkg::CMD_RECORD, 0, 0, 0);
        send(cmc_pkg::CMD_RECORD, 15, 15, 15);
        send(cmc_pkg::CMD_RECORD, 0, 15, 0);
        send(cmc_pkg::CMD_RECORD, 15, 0, 15);
        send(cmc_pkg::CMD_READ_CLASS, 0, 0, 0);
        send(cmc_pkg::CMD_READ_CLASS, 15, 15, 15);
        send(cmc_pkg::CMD_READ_CELL, 0, 15, 0);
        send(cmc_pkg::CMD_READ_CELL, 15, 0, 0);
        send(cmc_pkg::CMD_READ_TOTALS, 15, 15, 15);
        send(cmc_pkg::cmd_t'(5), 0, 0, 0);
        send(cmc_pkg::cmd_t'(7), 15, 15, 15);
        send(cmc_pkg::CMD_CLEAR, 0, 0, 0);
        send(cmc_pkg::CMD_READ_TOTALS, 0, 0, 0);
        send(cmc_pkg::CMD_RECORD, 3, 3, 0);
        // out-of-range classes, then counts kept across a range change
        set_classes(1);
        send(cmc_pkg::CMD_RECORD, 1, 0, 0);
        send(cmc_pkg::CMD_READ_CLASS, 0, 0, 1);
        send(cmc_pkg::CMD_RECORD, 0, 0, 0);
        send(cmc_pkg::CMD_READ_CLASS, 0, 0, 0);
        set_classes(0);
        send(cmc_pkg::CMD_RECORD, 0, 0, 0);
        send(cmc_pkg::CMD_READ_CELL, 0, 0, 0);
        send(cmc_pkg::CMD_READ_TOTALS, 0, 0, 0);
        set_classes(31);
        send(cmc_pkg::CMD_READ_CLASS, 0, 0, 3);

        random_items(350);
        set_classes(5);
        random_items(200);
        no_idle = 1'b1;
        set_classes(16);
        random_items(200);
        no_idle = 1'b0;
        set_classes(1);
        random_items(80);
        set_classes(0);
        random_items(30);
        set_classes(cmc_pkg::CFG_W'($urandom_range(2, 15)));
        random_items(200);
        set_classes(16);
        random_items(150);

        drain();
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/cmc_pkg.sv
rtl/core/cmc_ram.sv
rtl/core/cmc_divider.sv
rtl/core/classification_metrics_counter.sv
tb/classification_metrics_counter_tb.sv
